// ===== rtl/lzrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrc_pkg: shared types and constants of the LZ copy decoder
// Transfer payloads, the classified command passed from the front end to the
// back end, and the base complement used by reverse-complement copies.
// ----------------------------------------------------------------------------
`default_nettype none

package lzrc_pkg;

   // Input item
   typedef struct packed {
      logic        mode;
      logic [7:0]  literal_byte;
      logic [31:0] source_position;
      logic [6:0]  copy_length;
      logic        rc_copy;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0]  base;
      logic [31:0] out_position;
      logic        last_of_item;
      logic        end_of_block;
      logic        copy_error;
   } rsp_type;

   // Command classes
   localparam logic [1:0] KIND_LIT    = 2'd0;
   localparam logic [1:0] KIND_DROP   = 2'd1;
   localparam logic [1:0] KIND_COPY   = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   // Classified command, with the source bounds already summed
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  literal_byte;
      logic [31:0] source_position;
      logic [6:0]  copy_length;
      logic        rc_copy;
      logic [32:0] src_end;   // source + length
      logic [32:0] src_lim;   // source + window
   } cmd_type;

   // Nucleotide codes
   localparam logic [7:0] BASE_A = 8'h41;
   localparam logic [7:0] BASE_C = 8'h43;
   localparam logic [7:0] BASE_G = 8'h47;
   localparam logic [7:0] BASE_T = 8'h54;

   // A<->T, C<->G, anything else unchanged
   function automatic logic [7:0] base_partner(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         BASE_A:  r = BASE_T;
         BASE_T:  r = BASE_A;
         BASE_C:  r = BASE_G;
         BASE_G:  r = BASE_C;
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lzrc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module lzrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lzrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrc_front: input front end
// Classifies each accepted item, precomputes the source bounds of a match
// and holds the commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lzrc_front #(
   parameter int WINDOW    = 65536,
   parameter int MAX_MATCH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lzrc_pkg::req_type req_data,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready,
   output lzrc_pkg::cmd_type      cmd
);
   import lzrc_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;
   cmd_type    new_cmd;

   // classification
   always_comb begin
      new_cmd.literal_byte       = req_data.literal_byte;
      new_cmd.source_position    = req_data.source_position;
      new_cmd.copy_length        = req_data.copy_length;
      new_cmd.rc_copy            = req_data.rc_copy;
      new_cmd.src_end            = {1'b0, req_data.source_position}
                                   + {26'd0, req_data.copy_length};
      new_cmd.src_lim            = {1'b0, req_data.source_position} + 33'(WINDOW);
      if (!req_data.mode) begin
         new_cmd.kind = KIND_LIT;
      end else if (req_data.copy_length == 7'd0) begin
         new_cmd.kind = KIND_DROP;
      end else if (req_data.copy_length > 7'(MAX_MATCH)) begin
         new_cmd.kind = KIND_REJECT;
      end else begin
         new_cmd.kind = KIND_COPY;
      end
   end

   // queue control
   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lzrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrc_back: execution back end
// Emits literals, bound-checks and runs match copies from the history RAM.
// A copy reads its source while emitting, stages the bytes in a small buffer
// RAM, then sweeps them into the history so the source is never overwritten
// before it has been read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzrc_back #(
   parameter int WINDOW    = 65536,
   parameter int MAX_MATCH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [31:0]       block_length,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire lzrc_pkg::cmd_type cmd,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lzrc_pkg::rsp_type      rsp_data
);
   import lzrc_pkg::*;

   localparam int AW = $clog2(WINDOW);
   localparam int CW = $clog2(MAX_MATCH + 1);
   localparam int BW = $clog2(MAX_MATCH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;

   logic [1:0]    state_ff,   state_in;
   logic [31:0]   wp_ff,      wp_in;
   logic [AW-1:0] src_ff,     src_in;
   logic [CW-1:0] len_ff,     len_in;
   logic          rc_ff,      rc_in;
   logic [CW-1:0] icnt_ff,    icnt_in;
   logic [CW-1:0] ocnt_ff,    ocnt_in;
   logic          d_valid_ff, d_valid_in;
   logic          d_last_ff,  d_last_in;
   logic          wv_ff,      wv_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff,  rsp_data_in;

   logic          out_free;
   logic          d_free;
   logic          copy_bad;
   logic          eob;
   logic          emit;
   logic          emit_err;
   logic          emit_last;
   logic [7:0]    emit_base;
   logic [CW-1:0] offset;

   logic          h_we;
   logic [AW-1:0] h_waddr;
   logic [7:0]    h_wdata;
   logic          h_re;
   logic [AW-1:0] h_raddr;
   logic [7:0]    h_rdata;
   logic [7:0]    rd_byte;

   logic             b_we;
   logic             b_re;
   logic [AW+7:0]    b_wdata;
   logic [AW+7:0]    b_rdata;

   // history window
   lzrc_ram #(.WIDTH(8), .DEPTH(WINDOW)) u_history (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_en   (h_re),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   // staging buffer: {byte, history address}
   lzrc_ram #(.WIDTH(AW + 8), .DEPTH(MAX_MATCH)) u_stage (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (ocnt_ff[BW-1:0]),
      .wr_data (b_wdata),
      .rd_en   (b_re),
      .rd_addr (icnt_ff[BW-1:0]),
      .rd_data (b_rdata)
   );

   // shared terms
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign d_free   = !d_valid_ff || out_free;
   assign copy_bad = (cmd.src_end > {1'b0, wp_ff}) || (cmd.src_lim < {1'b0, wp_ff});
   assign eob      = (block_length != 32'd0) && (wp_ff == block_length - 32'd1);
   assign offset   = rc_ff ? (len_ff - CW'(1) - icnt_ff) : icnt_ff;
   assign h_raddr  = src_ff + AW'(offset);
   assign rd_byte  = rc_ff ? base_partner(h_rdata) : h_rdata;
   assign b_wdata  = {emit_base, wp_ff[AW-1:0]};

   // sequencer
   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      src_in     = src_ff;
      len_in     = len_ff;
      rc_in      = rc_ff;
      icnt_in    = icnt_ff;
      ocnt_in    = ocnt_ff;
      d_valid_in = d_valid_ff;
      d_last_in  = d_last_ff;
      wv_in      = 1'b0;
      cmd_ready  = 1'b0;
      emit       = 1'b0;
      emit_err   = 1'b0;
      emit_last  = 1'b0;
      emit_base  = 8'd0;
      h_we       = 1'b0;
      h_waddr    = wp_ff[AW-1:0];
      h_wdata    = cmd.literal_byte;
      h_re       = 1'b0;
      b_we       = 1'b0;
      b_re       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  KIND_LIT: begin
                     if (out_free) begin
                        cmd_ready = 1'b1;
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        emit_base = cmd.literal_byte;
                        h_we      = 1'b1;
                     end
                  end
                  KIND_DROP: begin
                     cmd_ready = 1'b1;
                  end
                  KIND_COPY: begin
                     if (copy_bad) begin
                        if (out_free) begin
                           cmd_ready = 1'b1;
                           emit      = 1'b1;
                           emit_err  = 1'b1;
                           emit_last = 1'b1;
                        end
                     end else begin
                        cmd_ready = 1'b1;
                        src_in    = cmd.source_position[AW-1:0];
                        len_in    = CW'(cmd.copy_length);
                        rc_in     = cmd.rc_copy;
                        icnt_in   = '0;
                        ocnt_in   = '0;
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     // over-long match
                     if (out_free) begin
                        cmd_ready = 1'b1;
                        emit      = 1'b1;
                        emit_err  = 1'b1;
                        emit_last = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            // emit the byte held at the RAM output
            if (d_valid_ff && out_free) begin
               emit       = 1'b1;
               emit_base  = rd_byte;
               emit_last  = d_last_ff;
               b_we       = 1'b1;
               ocnt_in    = ocnt_ff + CW'(1);
               d_valid_in = 1'b0;
               if (d_last_ff) begin
                  state_in = S_WRITE;
                  icnt_in  = '0;
               end
            end
            // issue the next source read
            if (icnt_ff != len_ff && d_free) begin
               h_re       = 1'b1;
               icnt_in    = icnt_ff + CW'(1);
               d_valid_in = 1'b1;
               d_last_in  = ((icnt_ff + CW'(1)) == len_ff);
            end
         end
         S_WRITE: begin
            if (icnt_ff != len_ff) begin
               b_re    = 1'b1;
               icnt_in = icnt_ff + CW'(1);
               wv_in   = 1'b1;
            end
            if (wv_ff) begin
               h_we    = 1'b1;
               h_waddr = b_rdata[AW-1:0];
               h_wdata = b_rdata[AW+7:AW];
               if (icnt_ff == len_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // position advance and block end restart
      if (emit && !emit_err) begin
         wp_in = eob ? 32'd0 : wp_ff + 32'd1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in             = emit || (rsp_valid_ff && !rsp_ready);
      rsp_data_in.base         = emit_err ? 8'd0 : emit_base;
      rsp_data_in.out_position = wp_ff;
      rsp_data_in.last_of_item = emit_last;
      rsp_data_in.end_of_block = !emit_err && eob;
      rsp_data_in.copy_error   = emit_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= 32'd0;
         icnt_ff      <= '0;
         ocnt_ff      <= '0;
         d_valid_ff   <= 1'b0;
         d_last_ff    <= 1'b0;
         wv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         icnt_ff      <= icnt_in;
         ocnt_ff      <= ocnt_in;
         d_valid_ff   <= d_valid_in;
         d_last_ff    <= d_last_in;
         wv_ff        <= wv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command and payload registers
   always_ff @(posedge clock) begin
      src_ff <= src_in;
      len_ff <= len_in;
      rc_ff  <= rc_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lz_copy_decoder_with_revcomp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_copy_decoder_with_revcomp: DNA LZ decoder with reverse-complement copies
// Input transfers on req_* carry a literal byte or a match command; every
// output byte leaves as one transfer on rsp_*. csr_* writes block_length.
// Usage:
//  - Literals stream at one per cycle while no copy is running and rsp_ready
//    stays high. Each result passes through the command queue and the
//    output register before it is offered on rsp_*.
//  - A match of length L occupies the back end for L history reads (results
//    leave as the reads return), then a sweep writing the staged bytes into
//    the history RAM, which has one read and one write port.
//  - A rejected match gives one error result; a zero-length match is
//    swallowed without a result.
//  - A two-entry command queue sits between front and back, so input keeps
//    flowing while a result waits in the output register.
//  - When rsp_ready is low the output register holds, the back end stops
//    and, once the queue fills, req_ready drops.
//  - Reset (synchronous) clears the position and block_length to zero; the
//    history is not cleared. csr_ready is always high; write it when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lz_copy_decoder_with_revcomp #(
   parameter int WINDOW    = 65536,
   parameter int MAX_MATCH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lzrc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lzrc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_data
);
   import lzrc_pkg::*;

   logic [31:0] blen_ff;
   logic [31:0] blen_in;
   logic        cmd_valid;
   logic        cmd_ready;
   cmd_type     cmd;

   // block length register
   assign csr_ready = 1'b1;
   assign blen_in   = (csr_valid && csr_ready) ? csr_data : blen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff <= 32'd0;
      end else begin
         blen_ff <= blen_in;
      end
   end

   // front end: classify and queue
   lzrc_front #(.WINDOW(WINDOW), .MAX_MATCH(MAX_MATCH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // back end: execute and emit
   lzrc_back #(.WINDOW(WINDOW), .MAX_MATCH(MAX_MATCH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .block_length (blen_ff),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/lzrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrc_checker: port-level checks of the LZ copy decoder
// Watches the result channel for reset behaviour, stall holding, position
// sequencing within an item, the shape of error results and csr acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module lzrc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire lzrc_pkg::rsp_type rsp_data,
   input wire logic              csr_valid,
   input wire logic              csr_ready
);
   import lzrc_pkg::*;

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // within one item positions run on, restarting at a block end
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_item ##1 rsp_valid |->
      rsp_data.out_position == ($past(rsp_data.end_of_block) ? 32'd0 :
                                $past(rsp_data.out_position) + 32'd1))
      else $error("position break inside an item");

   // an error result closes its item, never ends a block and carries a zero base
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.copy_error |->
      rsp_data.last_of_item && !rsp_data.end_of_block && rsp_data.base == 8'd0)
      else $error("malformed error result");

   // configuration is taken while no request is held back
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid && !(req_valid && !req_ready) |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind lz_copy_decoder_with_revcomp lzrc_checker u_checker (.*);

`default_nettype wire

// ===== tb/lz_copy_decoder_with_revcomp_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_copy_decoder_with_revcomp_test: self-checking bench for the LZ decoder
// Literal and match commands go in over req_*, decoded bytes come back on
// rsp_*. A shadow decoder predicts every byte, its position and its flags,
// and each rsp transfer is checked against the oldest prediction. The run
// steps through several block lengths and idling mixes.
// ----------------------------------------------------------------------------

module lz_copy_decoder_with_revcomp_test;
   import lzrc_pkg::*;

   localparam int HISTORY_DEPTH = 65536;
   localparam int LONGEST_COPY  = 64;
   // a long copy keeps sweeping the history after its last byte has left
   localparam int DRAIN_CYCLES  = 2 * LONGEST_COPY + 16;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data  = '0;

   // shadow decoder state
   logic [7:0]  history_bytes [0:HISTORY_DEPTH-1];
   logic [31:0] write_pos = '0;
   logic [31:0] block_len = '0;
   rsp_type     decoded_bytes [$];

   // stimulus bookkeeping; plan_* track the position as the queue is filled
   req_type     pending_items [$];
   int          items_queued   = 0;
   int          items_taken    = 0;
   logic [31:0] plan_pos       = '0;
   logic [31:0] plan_len       = '0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          phase          = 0;
   logic        hold_off       = 1'b0;
   int          errors         = 0;

   lz_copy_decoder_with_revcomp #(
      .WINDOW    (HISTORY_DEPTH),
      .MAX_MATCH (LONGEST_COPY)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // byte at pos completes the block
   function automatic bit ends_block(logic [31:0] pos, logic [31:0] blk);
      return blk != 0 && {1'b0, pos} + 33'd1 == {1'b0, blk};
   endfunction

   // too long, reaching past the write position, or older than the window
   function automatic bit copy_refused(logic [31:0] src, logic [6:0] len,
                                       logic [31:0] pos);
      logic [63:0] src_end;
      logic [63:0] src_lim;
      src_end = 64'(src) + 64'(len);
      src_lim = 64'(src) + 64'(HISTORY_DEPTH);
      return len > LONGEST_COPY || src_end > 64'(pos) || src_lim < 64'(pos);
   endfunction

   function automatic logic [7:0] paired_base(logic [7:0] b);
      case (b)
         BASE_A:  return BASE_T;
         BASE_T:  return BASE_A;
         BASE_C:  return BASE_G;
         BASE_G:  return BASE_C;
         default: return b;
      endcase
   endfunction

   // append one byte to the shadow history and expect it on rsp
   task automatic record_base(logic [7:0] b, bit last);
      rsp_type e;
      history_bytes[write_pos % HISTORY_DEPTH] = b;
      e.base         = b;
      e.out_position = write_pos;
      e.last_of_item = last;
      e.end_of_block = ends_block(write_pos, block_len);
      e.copy_error   = 1'b0;
      write_pos      = e.end_of_block ? '0 : write_pos + 1;
      decoded_bytes.insert(decoded_bytes.size(), e);
   endtask

   // expected bytes of one accepted command
   task automatic decode_item(req_type r);
      logic [7:0]  snap [0:LONGEST_COPY-1];
      logic [31:0] addr;
      rsp_type     e;
      if (r.mode == 1'b0) begin
         record_base(r.literal_byte, 1'b1);
      end else if (r.copy_length != 0) begin
         if (copy_refused(r.source_position, r.copy_length, write_pos)) begin
            e              = '0;
            e.out_position = write_pos;
            e.last_of_item = 1'b1;
            e.copy_error   = 1'b1;
            decoded_bytes.insert(decoded_bytes.size(), e);
         end else begin
            // read the whole source before writing, as the copy sees it
            for (int t = 0; t < r.copy_length; t++) begin
               if (r.rc_copy) begin
                  addr    = r.source_position + r.copy_length - 1 - t;
                  snap[t] = paired_base(history_bytes[addr % HISTORY_DEPTH]);
               end else begin
                  addr    = r.source_position + t;
                  snap[t] = history_bytes[addr % HISTORY_DEPTH];
               end
            end
            for (int t = 0; t < r.copy_length; t++)
               record_base(snap[t], t == r.copy_length - 1);
         end
      end
   endtask

   function automatic req_type make_item(bit mode, logic [7:0] lit,
                                         logic [31:0] src, logic [6:0] len,
                                         bit rc);
      req_type r;
      r.mode               = mode;
      r.literal_byte       = lit;
      r.source_position    = src;
      r.copy_length        = len;
      r.rc_copy            = rc;
      return r;
   endfunction

   function automatic logic [7:0] random_nucleotide();
      case ($urandom_range(3))
         0:       return BASE_A;
         1:       return BASE_C;
         2:       return BASE_G;
         default: return BASE_T;
      endcase
   endfunction

   // mostly short copies, a few of the longest
   function automatic logic [6:0] random_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70)
         return 7'($urandom_range(8, 1));
      else if (roll < 95)
         return 7'($urandom_range(LONGEST_COPY - 1, 9));
      else
         return 7'(LONGEST_COPY);
   endfunction

   task automatic queue_item(req_type r);
      int n;
      pending_items.insert(pending_items.size(), r);
      items_queued++;
      if (r.mode == 1'b0)
         n = 1;
      else if (r.copy_length != 0 &&
               !copy_refused(r.source_position, r.copy_length, plan_pos))
         n = r.copy_length;
      else
         n = 0;
      repeat (n) plan_pos = ends_block(plan_pos, plan_len) ? '0 : plan_pos + 1;
   endtask

   // literals, well-formed copies of written history, and some broken ones
   task automatic queue_random_items(int count);
      req_type     r;
      int          roll;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [31:0] reach;
      repeat (count) begin
         roll                 = $urandom_range(99);
         r.mode               = 1'b1;
         r.literal_byte       = 8'($urandom);
         r.source_position    = $urandom;
         r.copy_length        = random_length();
         r.rc_copy            = 1'($urandom);
         if (roll < 45) begin
            r.mode        = 1'b0;
            r.copy_length = 7'($urandom);
            if ($urandom_range(4) != 0)
               r.literal_byte = random_nucleotide();
         end else if (roll < 90) begin
            // a write position of zero leaves a random, refused source
            if (plan_pos != 0) begin
               if (r.copy_length > plan_pos)
                  r.copy_length = plan_pos[6:0];
               hi    = plan_pos - r.copy_length;
               lo    = plan_pos > HISTORY_DEPTH ? plan_pos - HISTORY_DEPTH : '0;
               reach = hi - lo;
               if ($urandom_range(1) == 0 && reach > 300)
                  reach = 300;
               r.source_position = hi - $urandom_range(reach);
            end
         end else begin
            case ($urandom_range(3))
               0:       r.copy_length = '0;
               1:       r.copy_length = 7'($urandom_range(127, LONGEST_COPY + 1));
               2:       r.source_position = plan_pos - r.copy_length + 1;
               default: r.source_position = $urandom;
            endcase
         end
         queue_item(r);
      end
   endtask

   // every command taken and every byte returned, then let the block finish
   task automatic settle();
      while (items_taken != items_queued || decoded_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_block_length(logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      block_len  = value;
   endtask

   task automatic begin_phase(int id, logic [31:0] blk, int send_pct,
                              int recv_pct);
      write_block_length(blk);
      plan_pos       = write_pos;
      plan_len       = block_len;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      phase          = id;
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 30)
            $display("%0t: %s expected %h got %h", $time, what, want, got);
      end
   endtask

   // request driver: predicts on each transfer, then offers the next item
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_item(req_data);
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_bytes.size() == 0) begin
               errors++;
               if (errors <= 30)
                  $display("%0t: result expected none got %h", $time, rsp_data);
            end else begin
               want = decoded_bytes.pop_front();
               check_field("base", 32'(want.base), 32'(rsp_data.base));
               check_field("out_position", want.out_position, rsp_data.out_position);
               check_field("last_of_item", 32'(want.last_of_item),
                           32'(rsp_data.last_of_item));
               check_field("end_of_block", 32'(want.end_of_block),
                           32'(rsp_data.end_of_block));
               check_field("copy_error", 32'(want.copy_error),
                           32'(rsp_data.copy_error));
            end
         end
         rsp_ready <= !hold_off && $urandom_range(99) >= recv_stall_pct;
      end
   end

   // long receiver hold-off so the command queue fills and req_ready drops
   initial begin : long_hold
      while (phase != 4) @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      logic [31:0] gap;
      logic [6:0]  run;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes, both copy directions, the refusals
      begin_phase(1, 32'd0, 0, 0);
      queue_item(make_item(1'b0, BASE_A, '0, '0, 1'b0));
      queue_item(make_item(1'b0, BASE_C, '0, '0, 1'b0));
      queue_item(make_item(1'b0, BASE_G, '0, '0, 1'b0));
      queue_item(make_item(1'b0, BASE_T, '0, '0, 1'b0));
      queue_item(make_item(1'b0, 8'h00, '0, '0, 1'b0));
      queue_item(make_item(1'b0, 8'hFF, '0, '0, 1'b0));
      queue_item(make_item(1'b0, 8'h4E, '0, '0, 1'b0));
      queue_item(make_item(1'b0, BASE_A, '0, '0, 1'b0));
      queue_item(make_item(1'b1, 8'h00, 32'd0, 7'd8, 1'b0));
      queue_item(make_item(1'b1, 8'h00, 32'd0, 7'd8, 1'b1));
      queue_item(make_item(1'b1, 8'h00, 32'd23, 7'd1, 1'b0));
      queue_item(make_item(1'b1, 8'h00, 32'd0, 7'd25, 1'b1));
      queue_item(make_item(1'b1, 8'h00, 32'd0, 7'd50, 1'b0));
      // source ends exactly at the write position
      queue_item(make_item(1'b1, 8'h00, 32'd36, 7'd64, 1'b1));
      queue_item(make_item(1'b1, 8'h00, 32'd100, 7'd64, 1'b0));
      // one byte past the write position, over-long, zero length, overflow
      queue_item(make_item(1'b1, 8'h00, 32'd228, 7'd1, 1'b0));
      queue_item(make_item(1'b1, 8'h00, 32'd0, 7'd65, 1'b0));
      queue_item(make_item(1'b1, 8'h00, 32'd0, 7'd127, 1'b1));
      queue_item(make_item(1'b1, 8'h00, 32'd5, 7'd0, 1'b0));
      queue_item(make_item(1'b1, 8'h00, 32'hFFFF_FFFF, 7'd64, 1'b0));
      // literal ignores every other field
      queue_item(make_item(1'b0, 8'hA5, '1, '1, 1'b1));
      queue_item(make_item(1'b1, 8'h00, 32'd228, 7'd1, 1'b0));
      queue_item(make_item(1'b1, 8'h00, 32'd229, 7'd1, 1'b1));
      settle();

      // short blocks with copies straddling the end; finish on a block end
      begin_phase(2, write_pos + 37, 0, 0);
      queue_random_items(70);
      while (plan_pos != 0) begin
         // close the block with copies that end exactly on it
         gap = plan_len - plan_pos;
         run = gap > LONGEST_COPY ? 7'(LONGEST_COPY) : gap[6:0];
         if (plan_pos >= run)
            queue_item(make_item(1'b1, 8'h00, plan_pos - run, run, 1'($urandom)));
         else
            queue_item(make_item(1'b0, random_nucleotide(), '0, '0, 1'b0));
      end
      settle();

      // one-byte blocks: every literal ends a block, every copy is refused
      begin_phase(3, 32'd1, 0, 47);
      queue_random_items(20);
      settle();

      begin_phase(4, '1, 47, 0);
      queue_random_items(90);
      settle();

      // block length already behind the position: no end marking
      begin_phase(5, 32'd23, 17, 17);
      queue_random_items(40);
      settle();

      begin_phase(6, write_pos + 50, 17, 17);
      queue_random_items(60);
      settle();

      // end marking switched off
      begin_phase(7, 32'd0, 0, 0);
      queue_random_items(20);
      settle();

      if (errors == 0) begin
         $display("PASS lz_copy_decoder_with_revcomp");
      end else begin
         $display("FAIL lz_copy_decoder_with_revcomp");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("FAIL lz_copy_decoder_with_revcomp");
      $finish;
   end

endmodule

// ===== lz_copy_decoder_with_revcomp.f =====
rtl/lzrc_pkg.sv
rtl/lzrc_ram.sv
rtl/lzrc_front.sv
rtl/lzrc_back.sv
rtl/lz_copy_decoder_with_revcomp.sv
rtl/lzrc_checker.sv
tb/lz_copy_decoder_with_revcomp_test.sv
